>>> hdl/bxavg_pkg.sv
// Shared types and constants for the box-average image downscaler.
package bxavg_pkg;

  // Payload field widths
  localparam int unsigned SRC_COL_W = 10;
  localparam int unsigned SRC_ROW_W = 9;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned COUNT_W   = 5;

  // Configuration register widths and reset values
  localparam int unsigned START_X_W = 10;
  localparam int unsigned START_Y_W = 9;
  localparam int unsigned STEP_W    = 26;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 26;
  localparam logic [STEP_W-1:0] STEP_RESET = 26'd476625;

  // Fixed-point centre arithmetic
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = OUT_IDX_W + STEP_W;
  localparam int unsigned COORD_W = 22;

  // Divider: averages never exceed 252, so eight quotient bits suffice
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned QUOT_CNT_W = 3;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_STEP_X  = 2'd2,
    REG_STEP_Y  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ORIGIN,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

>>> hdl/bxavg_if.sv
// Channel interfaces: request, result and configuration write.
interface bxavg_req_if;
  import bxavg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [SRC_COL_W-1:0] src_col;
  logic [SRC_ROW_W-1:0] src_row;
  logic [COLOR_W-1:0]   src_color;
  logic [OUT_IDX_W-1:0] out_col;
  logic [OUT_IDX_W-1:0] out_row;

  modport source(output valid, command, src_col, src_row, src_color, out_col, out_row,
                 input ready);
  modport sink(input valid, command, src_col, src_row, src_color, out_col, out_row,
               output ready);
endinterface

interface bxavg_rsp_if;
  import bxavg_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  avg_red;
  logic [CHAN_W-1:0]  avg_green;
  logic [CHAN_W-1:0]  avg_blue;
  logic [COLOR_W-1:0] packed_color;
  logic [COUNT_W-1:0] valid_count;

  modport source(output valid, avg_red, avg_green, avg_blue, packed_color, valid_count,
                 input ready);
  modport sink(input valid, avg_red, avg_green, avg_blue, packed_color, valid_count,
               output ready);
endinterface

interface bxavg_cfg_if;
  import bxavg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/bxavg_divider.sv
// Restoring divider, one quotient bit per cycle, three color lanes in step.
module bxavg_divider #(
  parameter int unsigned SUM_W = 13,
  parameter int unsigned CNT_W = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SUM_W-1:0]            sum_red,
  input  logic [SUM_W-1:0]            sum_green,
  input  logic [SUM_W-1:0]            sum_blue,
  input  logic [CNT_W-1:0]            divisor,
  output logic [bxavg_pkg::QUOT_W-1:0] quot_red,
  output logic [bxavg_pkg::QUOT_W-1:0] quot_green,
  output logic [bxavg_pkg::QUOT_W-1:0] quot_blue,
  output logic                        done
);
  import bxavg_pkg::*;

  localparam int unsigned LANES = 3;

  logic [SUM_W-1:0]      rem  [LANES];
  logic [QUOT_W-1:0]     quot [LANES];
  logic [SUM_W-1:0]      load [LANES];
  logic [SUM_W-1:0]      dsh;
  logic [QUOT_CNT_W-1:0] step;
  logic                  busy;

  assign load[0] = sum_red;
  assign load[1] = sum_green;
  assign load[2] = sum_blue;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == QUOT_CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare against divisor shifted to the current quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      dsh <= SUM_W'(divisor) << (QUOT_W - 1);
      for (int i = 0; i < LANES; i++) begin
        rem[i]  <= load[i];
        quot[i] <= '0;
      end
    end else if (busy) begin
      dsh <= dsh >> 1;
      for (int i = 0; i < LANES; i++) begin
        if (rem[i] >= dsh) begin
          rem[i]  <= rem[i] - dsh;
          quot[i] <= {quot[i][QUOT_W-2:0], 1'b1};
        end else begin
          quot[i] <= {quot[i][QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_red   = quot[0];
  assign quot_green = quot[1];
  assign quot_blue  = quot[2];

endmodule

>>> hdl/box_average_image_downscaler_core.sv
// Top level of the box-average image downscaler: frame memory, sequencer, output register.
//
// The block holds a SRC_WIDTH x SRC_HEIGHT frame of RGB565 pixels in one
// single-port memory. A write transaction (command 0) stores one pixel;
// writes outside the frame are dropped. A sample transaction (command 1)
// computes the centre cx = start_x + floor(out_col * step_x / 2^16) and likewise
// cy, with one shared 10x26 multiplier, then reads the (2*HALF_WINDOW)^2 window
// pixels from columns cx-HALF_WINDOW .. cx+HALF_WINDOW-1 and the same rows, one
// memory read per cycle, and accumulates the in-frame pixels with channels
// expanded to 8 bits (no bit replication). A shared restoring divider then
// forms all three averages, one quotient bit per cycle. From the accepting
// edge of a sample the request side stays low until the sequencer is back in
// idle, also while the final state waits for the output register, so a new
// request is taken only once the previous sample is done; the window scan
// through the single memory port and the bit-serial divider set how long a
// sample takes. The request side is ready only while the sequencer is idle.
// Results sit in an output register, so a new transaction is taken while a
// result waits; a sample that finishes before the previous result is taken
// holds in its final state. A window with no in-frame pixel returns zero
// averages, black and a count of zero. Frame memory contents are undefined
// after reset; reading an unwritten pixel returns unspecified data.
// Configuration writes are always ready and are meant only while the block
// is idle.
module box_average_image_downscaler_core #(
  parameter int unsigned SRC_WIDTH   = 640,
  parameter int unsigned SRC_HEIGHT  = 320,
  parameter int unsigned HALF_WINDOW = 2
) (
  input  logic        clk,
  input  logic        rst,
  bxavg_req_if.sink   req,
  bxavg_rsp_if.source rsp,
  bxavg_cfg_if.sink   cfg
);
  import bxavg_pkg::*;

  localparam int unsigned DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WIN   = 2 * HALF_WINDOW;
  localparam int unsigned KW    = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int unsigned CNT_W = $clog2(WIN * WIN + 1);
  localparam int unsigned SUM_W = CHAN_W + CNT_W;

  // Configuration registers
  logic [START_X_W-1:0] start_x;
  logic [START_Y_W-1:0] start_y;
  logic [STEP_W-1:0]    step_x;
  logic [STEP_W-1:0]    step_y;

  // Sequencer
  state_t state, state_next;
  logic   req_take;
  logic   div_start;
  logic   out_load;

  // Centre and window
  logic [OUT_IDX_W-1:0] col_q;
  logic [OUT_IDX_W-1:0] row_q;
  logic [OUT_IDX_W-1:0] mul_a;
  logic [STEP_W-1:0]    mul_b;
  logic [PROD_W-1:0]    prod;
  logic [COORD_W-1:0]   ox;
  logic [COORD_W-1:0]   oy;
  logic [KW-1:0]        kx;
  logic [KW-1:0]        ky;
  logic [COORD_W-1:0]   wx;
  logic [COORD_W-1:0]   wy;
  logic                 in_frame;
  logic                 scan_last;

  // Frame memory
  logic [COLOR_W-1:0] frame [DEPTH];
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [COLOR_W-1:0] rd_data;
  logic               rd_pend;

  // Accumulators
  logic [SUM_W-1:0] sum_red;
  logic [SUM_W-1:0] sum_green;
  logic [SUM_W-1:0] sum_blue;
  logic [CNT_W-1:0] count;

  // Divider
  logic [QUOT_W-1:0] quot_red;
  logic [QUOT_W-1:0] quot_green;
  logic [QUOT_W-1:0] quot_blue;
  logic              div_done;

  // Output register
  logic               out_valid;
  logic [CHAN_W-1:0]  out_red;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_blue;
  logic [COLOR_W-1:0] out_color;
  logic [COUNT_W-1:0] out_count;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, values truncated to register width
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      step_x  <= STEP_RESET;
      step_y  <= STEP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_START_X: start_x <= cfg.data[START_X_W-1:0];
        REG_START_Y: start_y <= cfg.data[START_Y_W-1:0];
        REG_STEP_X:  step_x  <= cfg.data[STEP_W-1:0];
        REG_STEP_Y:  step_y  <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign scan_last = (kx == KW'(WIN - 1)) && (ky == KW'(WIN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_take   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_take = req.valid;
        if (req.valid && req.command == CMD_SAMPLE) begin
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X:  state_next = ST_MUL_Y;
      ST_MUL_Y:  state_next = ST_ORIGIN;
      ST_ORIGIN: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last pixel lands in the accumulators during this cycle
      ST_DRAIN: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Centre computation on the shared multiplier, then window origin
  // ---------------------------------------------------------------------------
  assign mul_a = (state == ST_MUL_X) ? col_q  : row_q;
  assign mul_b = (state == ST_MUL_X) ? step_x : step_y;

  always_ff @(posedge clk) begin
    if (req_take) begin
      col_q <= req.out_col;
      row_q <= req.out_row;
    end
    if (state == ST_MUL_X || state == ST_MUL_Y) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state == ST_MUL_Y) begin
      ox <= COORD_W'(start_x) + COORD_W'(prod[PROD_W-1:FRAC_W]) - COORD_W'(HALF_WINDOW);
    end
    if (state == ST_ORIGIN) begin
      oy <= COORD_W'(start_y) + COORD_W'(prod[PROD_W-1:FRAC_W]) - COORD_W'(HALF_WINDOW);
    end
  end

  // Window scan: row-major, one pixel per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      kx <= '0;
      ky <= '0;
    end else if (state == ST_SCAN) begin
      if (kx == KW'(WIN - 1)) begin
        kx <= '0;
        ky <= ky + 1'b1;
      end else begin
        kx <= kx + 1'b1;
      end
    end else begin
      kx <= '0;
      ky <= '0;
    end
  end

  // A coordinate left of or above the frame wraps to a large unsigned value,
  // so a single unsigned compare covers both edges.
  assign wx       = ox + COORD_W'(kx);
  assign wy       = oy + COORD_W'(ky);
  assign in_frame = (wx < COORD_W'(SRC_WIDTH)) && (wy < COORD_W'(SRC_HEIGHT));

  // ---------------------------------------------------------------------------
  // Frame memory: one write or one read per cycle
  // ---------------------------------------------------------------------------
  assign wr_en = req_take && (req.command == CMD_WRITE) &&
                 (32'(req.src_col) < SRC_WIDTH) && (32'(req.src_row) < SRC_HEIGHT);
  assign wr_addr = AW'(req.src_row) * AW'(SRC_WIDTH) + AW'(req.src_col);
  assign rd_en   = (state == ST_SCAN) && in_frame;
  assign rd_addr = AW'(wy) * AW'(SRC_WIDTH) + AW'(wx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame[wr_addr] <= req.src_color;
    end
    if (rd_en) begin
      rd_data <= frame[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate in-frame pixels, channels expanded to 8 bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req_take) begin
      sum_red   <= '0;
      sum_green <= '0;
      sum_blue  <= '0;
      count     <= '0;
    end else if (rd_pend) begin
      sum_red   <= sum_red   + SUM_W'({rd_data[15:11], 3'b000});
      sum_green <= sum_green + SUM_W'({rd_data[10:5],  2'b00});
      sum_blue  <= sum_blue  + SUM_W'({rd_data[4:0],   3'b000});
      count     <= count + 1'b1;
    end
  end

  bxavg_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .sum_red    (sum_red),
    .sum_green  (sum_green),
    .sum_blue   (sum_blue),
    .divisor    (count),
    .quot_red   (quot_red),
    .quot_green (quot_green),
    .quot_blue  (quot_blue),
    .done       (div_done)
  );

  // ---------------------------------------------------------------------------
  // Output register; an empty window gives black
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count <= COUNT_W'(count);
      if (count == '0) begin
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
        out_color <= '0;
      end else begin
        out_red   <= quot_red;
        out_green <= quot_green;
        out_blue  <= quot_blue;
        out_color <= {quot_red[7:3], quot_green[7:2], quot_blue[7:3]};
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.avg_red      = out_red;
  assign rsp.avg_green    = out_green;
  assign rsp.avg_blue     = out_blue;
  assign rsp.packed_color = out_color;
  assign rsp.valid_count  = out_count;

endmodule

>>> sim/box_average_image_downscaler_core_tb.sv
// Self-checking testbench for the box-average image downscaler core.
`timescale 1ns / 100ps

module box_average_image_downscaler_core_tb;
  import bxavg_pkg::*;

  localparam int FRAME_W         = 640;
  localparam int FRAME_H         = 320;
  localparam int HALF_WIN        = 2;
  localparam int FRAME_PIXELS    = FRAME_W * FRAME_H;
  localparam int FRAME_AW        = $clog2(FRAME_PIXELS);
  localparam int ITEM_TARGET     = 1550;
  localparam int GAP_MAX         = 17;
  localparam int SETTLE_CYCLES   = 40;    // longer than one whole sample
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int STALL_LIMIT     = 5000;  // cycles with no transaction on any channel
  localparam int REPORT_LIMIT    = 10;
  localparam int IDX_MAX         = 2**OUT_IDX_W - 1;

  typedef struct packed {
    cmd_t                 command;
    logic [SRC_COL_W-1:0] src_col;
    logic [SRC_ROW_W-1:0] src_row;
    logic [COLOR_W-1:0]   src_color;
    logic [OUT_IDX_W-1:0] out_col;
    logic [OUT_IDX_W-1:0] out_row;
  } pixel_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COLOR_W-1:0] rgb565;
    logic [COUNT_W-1:0] pixels;
  } box_avg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bxavg_req_if req_ch();
  bxavg_rsp_if rsp_ch();
  bxavg_cfg_if cfg_ch();

  box_average_image_downscaler_core #(
    .SRC_WIDTH  (FRAME_W),
    .SRC_HEIGHT (FRAME_H),
    .HALF_WINDOW(HALF_WIN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Shadow of the frame memory and of the four registers. frame_set marks every
  // location that has been written, so no sample ever reads an undefined pixel.
  logic [COLOR_W-1:0]   frame_pix [FRAME_PIXELS];
  bit                   frame_set [FRAME_PIXELS];
  logic [START_X_W-1:0] cur_start_x;
  logic [START_Y_W-1:0] cur_start_y;
  logic [STEP_W-1:0]    cur_step_x;
  logic [STEP_W-1:0]    cur_step_y;

  box_avg_t expected_avgs[$];
  box_avg_t got_avg;
  box_avg_t want_avg;

  int req_gap_max  = GAP_MAX;
  int rsp_gap_max  = GAP_MAX;
  int rsp_gap      = 0;
  bit rsp_fired    = 1'b0;
  bit rsp_hold     = 1'b0;
  int hold_request = 0;
  int items_sent   = 0;
  int error_count  = 0;
  int idle_cycles  = 0;

  // Remember the last sample so later items can revisit and overwrite its window.
  logic [OUT_IDX_W-1:0] last_oc = '0;
  logic [OUT_IDX_W-1:0] last_orow = '0;
  int last_cx = 0;
  int last_cy = 0;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Centre = start + floor(index * step / 2^16), exact in 36 bits.
  function automatic int centre_of(input int start, input logic [OUT_IDX_W-1:0] idx,
                                   input logic [STEP_W-1:0] step);
    logic [PROD_W-1:0] prod;
    prod = idx * step;
    return start + int'(prod[PROD_W-1:FRAC_W]);
  endfunction

  function automatic bit in_frame(input int x, input int y);
    return x >= 0 && x < FRAME_W && y >= 0 && y < FRAME_H;
  endfunction

  // Shadow location of an in-frame pixel.
  function automatic logic [FRAME_AW-1:0] pix_at(input int x, input int y);
    return FRAME_AW'(y * FRAME_W + x);
  endfunction

  // Average the in-frame pixels of the window; channels expand by a plain shift.
  function automatic box_avg_t predict_box(input logic [OUT_IDX_W-1:0] oc,
                                           input logic [OUT_IDX_W-1:0] orow);
    int cx, cy, wx, wy, sum_r, sum_g, sum_b, n;
    logic [COLOR_W-1:0] p;
    box_avg_t r;
    cx = centre_of(cur_start_x, oc, cur_step_x);
    cy = centre_of(cur_start_y, orow, cur_step_y);
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (wx = cx - HALF_WIN; wx < cx + HALF_WIN; wx++) begin
      for (wy = cy - HALF_WIN; wy < cy + HALF_WIN; wy++) begin
        if (in_frame(wx, wy)) begin
          p = frame_pix[pix_at(wx, wy)];
          sum_r += {p[15:11], 3'b000};
          sum_g += {p[10:5], 2'b00};
          sum_b += {p[4:0], 3'b000};
          n++;
        end
      end
    end
    r = '0;
    // An empty window stays black with a zero count.
    if (n > 0) begin
      r.red    = CHAN_W'(sum_r / n);
      r.green  = CHAN_W'(sum_g / n);
      r.blue   = CHAN_W'(sum_b / n);
      r.rgb565 = {r.red[7:3], r.green[7:2], r.blue[7:3]};
    end
    r.pixels = COUNT_W'(n);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Randomize every field, including the ones the command does not use.
  function automatic pixel_req_t random_item(input cmd_t cmd);
    pixel_req_t it;
    it.command   = cmd;
    it.src_col   = SRC_COL_W'($urandom_range(0, 2**SRC_COL_W - 1));
    it.src_row   = SRC_ROW_W'($urandom_range(0, 2**SRC_ROW_W - 1));
    it.src_color = COLOR_W'($urandom_range(0, 2**COLOR_W - 1));
    it.out_col   = OUT_IDX_W'($urandom_range(0, IDX_MAX));
    it.out_row   = OUT_IDX_W'($urandom_range(0, IDX_MAX));
    return it;
  endfunction

  // Largest index whose centre can still touch the frame, clamped to the field.
  function automatic int index_span(input int start, input int step, input int size);
    longint span;
    if (step == 0 || start >= size + HALF_WIN) return IDX_MAX;
    span = (longint'(size + HALF_WIN - start) << FRAC_W) / step;
    return (span > IDX_MAX) ? IDX_MAX : int'(span);
  endfunction

  function automatic logic [CFG_DAT_W-1:0] random_start(input int size);
    // Now and then send full-width data to exercise the register masking.
    if ($urandom_range(0, 4) == 0) return CFG_DAT_W'($urandom_range(0, 2**CFG_DAT_W - 1));
    return CFG_DAT_W'($urandom_range(0, size - 1));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] random_step();
    case ($urandom_range(0, 4))
      0:       return CFG_DAT_W'($urandom_range(16384, 131072));
      1:       return CFG_DAT_W'($urandom_range(300000, 700000));
      2:       return CFG_DAT_W'($urandom_range(0, 2**STEP_W - 1));
      3:       return CFG_DAT_W'($urandom_range(0, 16383));
      default: return CFG_DAT_W'($urandom_range(131072, 1048576));
    endcase
  endfunction

  // Offer one request transaction after a random gap and update the shadow
  // state once it is accepted. Valid stays high on return, so a back-to-back
  // call keeps the channel busy; wait_idle drops it.
  task automatic send_request(input pixel_req_t it);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.command   <= it.command;
    req_ch.src_col   <= it.src_col;
    req_ch.src_row   <= it.src_row;
    req_ch.src_color <= it.src_color;
    req_ch.out_col   <= it.out_col;
    req_ch.out_row   <= it.out_row;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (it.command == CMD_WRITE) begin
      // Drop writes outside the frame, as the block does.
      if (in_frame(it.src_col, it.src_row)) begin
        frame_pix[pix_at(it.src_col, it.src_row)] = it.src_color;
        frame_set[pix_at(it.src_col, it.src_row)] = 1'b1;
      end
    end else begin
      expected_avgs.push_back(predict_box(it.out_col, it.out_row));
    end
    items_sent++;
  endtask

  // Sample one output pixel. First write every in-frame window pixel that was
  // never written, so the block only ever reads defined memory.
  task automatic sample_at(input logic [OUT_IDX_W-1:0] oc, input logic [OUT_IDX_W-1:0] orow);
    int cx, cy, wx, wy;
    pixel_req_t it;
    cx = centre_of(cur_start_x, oc, cur_step_x);
    cy = centre_of(cur_start_y, orow, cur_step_y);
    for (wx = cx - HALF_WIN; wx < cx + HALF_WIN; wx++) begin
      for (wy = cy - HALF_WIN; wy < cy + HALF_WIN; wy++) begin
        if (in_frame(wx, wy) && !frame_set[pix_at(wx, wy)]) begin
          it = random_item(CMD_WRITE);
          it.src_col = SRC_COL_W'(wx);
          it.src_row = SRC_ROW_W'(wy);
          send_request(it);
        end
      end
    end
    it = random_item(CMD_SAMPLE);
    it.out_col = oc;
    it.out_row = orow;
    send_request(it);
    last_oc   = oc;
    last_orow = orow;
    last_cx   = cx;
    last_cy   = cy;
  endtask

  // Mix of samples mostly aimed at the frame, revisits, overwrites near the
  // last window and writes that fall outside the frame.
  task automatic run_mix(input int n);
    int kind, wx, wy;
    pixel_req_t it;
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        sample_at(OUT_IDX_W'($urandom_range(0, index_span(cur_start_x, cur_step_x, FRAME_W))),
                  OUT_IDX_W'($urandom_range(0, index_span(cur_start_y, cur_step_y, FRAME_H))));
      end else if (kind < 55) begin
        sample_at(OUT_IDX_W'($urandom_range(0, IDX_MAX)), OUT_IDX_W'($urandom_range(0, IDX_MAX)));
      end else if (kind < 65) begin
        sample_at(last_oc, last_orow);
      end else if (kind < 90) begin
        it = random_item(CMD_WRITE);
        wx = last_cx - HALF_WIN + int'($urandom_range(0, 2 * HALF_WIN - 1));
        wy = last_cy - HALF_WIN + int'($urandom_range(0, 2 * HALF_WIN - 1));
        if (in_frame(wx, wy) && $urandom_range(0, 1)) begin
          it.src_col = SRC_COL_W'(wx);
          it.src_row = SRC_ROW_W'(wy);
        end else begin
          it.src_col = SRC_COL_W'($urandom_range(0, FRAME_W - 1));
          it.src_row = SRC_ROW_W'($urandom_range(0, FRAME_H - 1));
        end
        send_request(it);
      end else begin
        it = random_item(CMD_WRITE);
        if ($urandom_range(0, 1))
          it.src_col = SRC_COL_W'($urandom_range(FRAME_W, 2**SRC_COL_W - 1));
        else
          it.src_row = SRC_ROW_W'($urandom_range(FRAME_H, 2**SRC_ROW_W - 1));
        send_request(it);
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    // Mask to the register width, as the block does.
    case (idx)
      REG_START_X: cur_start_x = value[START_X_W-1:0];
      REG_START_Y: cur_start_y = value[START_Y_W-1:0];
      REG_STEP_X:  cur_step_x  = value[STEP_W-1:0];
      REG_STEP_Y:  cur_step_y  = value[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_window_config(input logic [CFG_DAT_W-1:0] sx, input logic [CFG_DAT_W-1:0] sy,
                                   input logic [CFG_DAT_W-1:0] stx,
                                   input logic [CFG_DAT_W-1:0] sty);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_STEP_X, stx);
    write_reg(REG_STEP_Y, sty);
  endtask

  // Drop valid, wait for every expected result, then let a trailing write or
  // sample run out before touching the registers.
  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run on the reset registers: extreme colours in the corner window, an empty
  // window far outside the frame, dropped out-of-frame writes and the partial
  // window at the far corner.
  task automatic test_reset_state();
    pixel_req_t it;
    it = random_item(CMD_WRITE);
    it.src_col   = 0;
    it.src_row   = 0;
    it.src_color = 16'hFFFF;
    send_request(it);
    it.src_col   = 1;
    it.src_color = 16'h0000;
    send_request(it);
    it.src_col   = 0;
    it.src_row   = 1;
    it.src_color = 16'hF800;
    send_request(it);
    it.src_col   = 1;
    it.src_color = 16'h07E0;
    send_request(it);
    sample_at(0, 0);
    sample_at(OUT_IDX_W'(IDX_MAX), OUT_IDX_W'(IDX_MAX));
    // Writes just past and far past the frame must leave the corner untouched.
    it.src_col   = SRC_COL_W'(2**SRC_COL_W - 1);
    it.src_row   = SRC_ROW_W'(2**SRC_ROW_W - 1);
    it.src_color = 16'hFFFF;
    send_request(it);
    it.src_col = SRC_COL_W'(FRAME_W);
    it.src_row = 0;
    send_request(it);
    it.src_col = 0;
    it.src_row = SRC_ROW_W'(FRAME_H);
    send_request(it);
    sample_at(0, 0);
    // With the reset step, index 88/44 lands on the last column and row.
    sample_at(88, 44);
    sample_at(89, 44);
    sample_at(88, 45);
    wait_idle();
  endtask

  // Sweep the registers through their extremes.
  task automatic test_register_extremes();
    // Zero step pins every centre to the origin: a four-pixel corner window.
    wait_idle();
    set_window_config(0, 0, 0, 0);
    run_mix(12);
    // Pin the centre to the far corner: nine pixels in the frame.
    wait_idle();
    set_window_config(CFG_DAT_W'(FRAME_W - 1), CFG_DAT_W'(FRAME_H - 1), 0, 0);
    run_mix(12);
    // All-ones data masks to 1023 and 511, well beyond the frame.
    wait_idle();
    set_window_config('1, '1, 0, 0);
    run_mix(8);
    // Largest step: only index zero stays inside the frame.
    wait_idle();
    set_window_config(0, 0, '1, '1);
    run_mix(12);
    // Unit step from the middle of the frame.
    wait_idle();
    set_window_config(CFG_DAT_W'(FRAME_W / 2), CFG_DAT_W'(FRAME_H / 2),
                      CFG_DAT_W'(1 << FRAC_W), CFG_DAT_W'(1 << FRAC_W));
    run_mix(30);
  endtask

  // Hold off the result side for a long stretch while requests keep coming, so
  // the output register fills, a finished sample waits and the input stalls.
  task automatic test_output_backpressure();
    req_gap_max  = 0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (12) begin
      sample_at(OUT_IDX_W'($urandom_range(0, index_span(cur_start_x, cur_step_x, FRAME_W))),
                OUT_IDX_W'($urandom_range(0, index_span(cur_start_y, cur_step_y, FRAME_H))));
    end
    wait_idle();
    req_gap_max = GAP_MAX;
  endtask

  // Random register settings, each followed by a burst of mixed traffic. Every
  // fourth phase runs with no idling on either side.
  task automatic test_random_traffic();
    int phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      set_window_config(random_start(FRAME_W), random_start(FRAME_H),
                        random_step(), random_step());
      if (phase % 4 == 3) begin
        req_gap_max = 0;
        rsp_gap_max = 0;
      end else begin
        req_gap_max = GAP_MAX;
        rsp_gap_max = GAP_MAX;
      end
      run_mix(40);
      phase++;
    end
    req_gap_max = GAP_MAX;
    rsp_gap_max = GAP_MAX;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Draw a fresh gap after every transaction; keep ready low during a hold-off.
  always @(negedge clk) begin
    if (rsp_fired) rsp_gap = $urandom_range(0, rsp_gap_max);
    else if (rsp_gap > 0) rsp_gap = rsp_gap - 1;
    rsp_ch.ready <= !rst && rsp_gap == 0 && !rsp_hold;
  end

  // Count the hold-off in its own process.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        rsp_hold <= 1'b1;
        repeat (hold_request) @(posedge clk);
        rsp_hold <= 1'b0;
        hold_request = 0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rsp_fired <= !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_avg.red    = rsp_ch.avg_red;
      got_avg.green  = rsp_ch.avg_green;
      got_avg.blue   = rsp_ch.avg_blue;
      got_avg.rgb565 = rsp_ch.packed_color;
      got_avg.pixels = rsp_ch.valid_count;
      if (expected_avgs.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("unexpected result: r=%0d g=%0d b=%0d rgb=%h n=%0d",
                   got_avg.red, got_avg.green, got_avg.blue, got_avg.rgb565, got_avg.pixels);
        error_count++;
      end else begin
        want_avg = expected_avgs.pop_front();
        if (got_avg.red !== want_avg.red || got_avg.green !== want_avg.green ||
            got_avg.blue !== want_avg.blue || got_avg.rgb565 !== want_avg.rgb565 ||
            got_avg.pixels !== want_avg.pixels) begin
          if (error_count < REPORT_LIMIT)
            $display("mismatch: expected r=%0d g=%0d b=%0d rgb=%h n=%0d, got r=%0d g=%0d b=%0d rgb=%h n=%0d",
                     want_avg.red, want_avg.green, want_avg.blue, want_avg.rgb565,
                     want_avg.pixels, got_avg.red, got_avg.green, got_avg.blue,
                     got_avg.rgb565, got_avg.pixels);
          error_count++;
        end
      end
    end
  end

  // End the run when no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_WRITE;
    req_ch.src_col   = '0;
    req_ch.src_row   = '0;
    req_ch.src_color = '0;
    req_ch.out_col   = '0;
    req_ch.out_row   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_START_X;
    cfg_ch.data      = '0;
    rsp_ch.ready     = 1'b0;
    cur_start_x      = '0;
    cur_start_y      = '0;
    cur_step_x       = STEP_RESET;
    cur_step_y       = STEP_RESET;

    // Hold reset, then release it away from the active edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
